[rtl/cursor_sprite_run_rectangles_defines.svh]
`ifndef CURSOR_SPRITE_RUN_RECTANGLES_DEFINES_SVH
`define CURSOR_SPRITE_RUN_RECTANGLES_DEFINES_SVH

// same-cycle implication
`define CSPR_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CSPR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/cspr_pkg.sv]
package cspr_pkg;

   localparam int RUN_COUNT = 52;
   localparam int RUN_IDX_W = 6;
   localparam int FRAME_LIMIT = 4096;

   typedef logic signed [12:0] coord_type;
   typedef logic signed [13:0] base_type;
   typedef logic signed [14:0] geo_type;
   typedef logic [12:0] frame_type;
   typedef logic [4:0] scale_type;
   typedef logic [8:0] prod_type;
   typedef logic [11:0] pos_type;
   typedef logic [12:0] size_type;
   typedef logic [RUN_IDX_W-1:0] run_idx_type;

   typedef enum logic [1:0] {
      CSR_FRAME_WIDTH  = 2'd0,
      CSR_FRAME_HEIGHT = 2'd1,
      CSR_CELL_SCALE   = 2'd2
   } csr_index_type;

   typedef enum logic {
      SEQ_IDLE = 1'b0,
      SEQ_RUN  = 1'b1
   } seq_state_type;

   typedef struct packed {
      logic [4:0] row;
      logic [3:0] col;
      logic [3:0] len;
      logic       color;
   } run_type;

   // dark outline runs, then light fill runs, in row order
   localparam run_type RUN_TABLE [RUN_COUNT] = '{
      '{5'd0,  4'd0, 4'd1, 1'b0}, '{5'd1,  4'd0, 4'd2, 1'b0},
      '{5'd2,  4'd0, 4'd1, 1'b0}, '{5'd2,  4'd2, 4'd1, 1'b0},
      '{5'd3,  4'd0, 4'd1, 1'b0}, '{5'd3,  4'd3, 4'd1, 1'b0},
      '{5'd4,  4'd0, 4'd1, 1'b0}, '{5'd4,  4'd4, 4'd1, 1'b0},
      '{5'd5,  4'd0, 4'd1, 1'b0}, '{5'd5,  4'd5, 4'd1, 1'b0},
      '{5'd6,  4'd0, 4'd1, 1'b0}, '{5'd6,  4'd6, 4'd1, 1'b0},
      '{5'd7,  4'd0, 4'd1, 1'b0}, '{5'd7,  4'd7, 4'd1, 1'b0},
      '{5'd8,  4'd0, 4'd1, 1'b0}, '{5'd8,  4'd8, 4'd1, 1'b0},
      '{5'd9,  4'd0, 4'd1, 1'b0}, '{5'd9,  4'd9, 4'd1, 1'b0},
      '{5'd10, 4'd0, 4'd1, 1'b0}, '{5'd10, 4'd6, 4'd5, 1'b0},
      '{5'd11, 4'd0, 4'd1, 1'b0}, '{5'd11, 4'd3, 4'd1, 1'b0},
      '{5'd11, 4'd6, 4'd1, 1'b0},
      '{5'd12, 4'd0, 4'd1, 1'b0}, '{5'd12, 4'd2, 4'd1, 1'b0},
      '{5'd12, 4'd4, 4'd1, 1'b0}, '{5'd12, 4'd7, 4'd1, 1'b0},
      '{5'd13, 4'd0, 4'd2, 1'b0}, '{5'd13, 4'd4, 4'd1, 1'b0},
      '{5'd13, 4'd7, 4'd1, 1'b0},
      '{5'd14, 4'd0, 4'd1, 1'b0}, '{5'd14, 4'd5, 4'd1, 1'b0},
      '{5'd14, 4'd8, 4'd1, 1'b0},
      '{5'd15, 4'd5, 4'd1, 1'b0}, '{5'd15, 4'd8, 4'd1, 1'b0},
      '{5'd16, 4'd6, 4'd2, 1'b0},
      '{5'd2,  4'd1, 4'd1, 1'b1}, '{5'd3,  4'd1, 4'd2, 1'b1},
      '{5'd4,  4'd1, 4'd3, 1'b1}, '{5'd5,  4'd1, 4'd4, 1'b1},
      '{5'd6,  4'd1, 4'd5, 1'b1}, '{5'd7,  4'd1, 4'd6, 1'b1},
      '{5'd8,  4'd1, 4'd7, 1'b1}, '{5'd9,  4'd1, 4'd8, 1'b1},
      '{5'd10, 4'd1, 4'd5, 1'b1},
      '{5'd11, 4'd1, 4'd2, 1'b1}, '{5'd11, 4'd4, 4'd2, 1'b1},
      '{5'd12, 4'd1, 4'd1, 1'b1}, '{5'd12, 4'd5, 4'd2, 1'b1},
      '{5'd13, 4'd5, 4'd2, 1'b1}, '{5'd14, 4'd6, 4'd2, 1'b1},
      '{5'd15, 4'd6, 4'd2, 1'b1}
   };

   typedef struct packed {
      logic        valid;
      logic        last_run;
      run_idx_type idx;
      coord_type   x;
      base_type    base;
   } issue_type;

   typedef struct packed {
      logic     valid;
      logic     last_run;
      logic     keep;
      logic     color;
      pos_type  x;
      pos_type  y;
      size_type w;
      size_type h;
   } rect_type;

   function automatic frame_type frame_clamp(input frame_type dim);
      frame_type lim;
      lim = frame_type'(FRAME_LIMIT);
      return (dim > lim) ? lim : dim;
   endfunction

endpackage

[rtl/cursor_sprite_run_rectangles.sv]
// path: a drawn request's first rectangle passes the sequencer, the table read, placement and
// clipping stages and a hold slot, where it waits for the next surviving run or the walk's end,
// then the output register; throughput: at most one rectangle per cycle, none under rsp_stall;
// a drawn request keeps req_stall high while the 52 run table entries issue, one per cycle unless
// rsp_stall holds them, the next after the walk ends; a request drawing nothing keeps it low
// reset: synchronous, active high; clears the pipeline and sets width 0, height 0, scale 1
`include "cursor_sprite_run_rectangles_defines.svh"

module cursor_sprite_run_rectangles (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  cspr_pkg::coord_type  req_hot_x,
   input  cspr_pkg::coord_type  req_hot_y,
   input  logic                 req_shown,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output cspr_pkg::pos_type    rsp_rect_x,
   output cspr_pkg::pos_type    rsp_rect_y,
   output cspr_pkg::size_type   rsp_rect_w,
   output cspr_pkg::size_type   rsp_rect_h,
   output logic                 rsp_fill_color,
   output logic                 rsp_last,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [1:0]           csr_index,
   input  logic [12:0]          csr_data
);

   cspr_pkg::frame_type frame_width_ff, frame_width_in;
   cspr_pkg::frame_type frame_height_ff, frame_height_in;
   cspr_pkg::scale_type cell_scale_ff, cell_scale_in;
   cspr_pkg::issue_type issue;
   cspr_pkg::rect_type  rect;
   logic                advance;
   logic                draw_accept;
   logic                rect_empty;
   logic                idx_past_end;

   assign csr_ready = 1'b1;

   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      cell_scale_in   = cell_scale_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            cspr_pkg::CSR_FRAME_WIDTH:  frame_width_in  = csr_data;
            cspr_pkg::CSR_FRAME_HEIGHT: frame_height_in = csr_data;
            cspr_pkg::CSR_CELL_SCALE:   cell_scale_in   = csr_data[4:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= '0;
         frame_height_ff <= '0;
         cell_scale_ff   <= cspr_pkg::scale_type'(1);
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         cell_scale_ff   <= cell_scale_in;
      end
   end

   cspr_sequencer u_sequencer (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_hot_x    (req_hot_x),
      .req_hot_y    (req_hot_y),
      .req_shown    (req_shown),
      .frame_width  (frame_width_ff),
      .frame_height (frame_height_ff),
      .advance      (advance),
      .issue        (issue)
   );

   cspr_geometry u_geometry (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .issue        (issue),
      .frame_width  (frame_width_ff),
      .frame_height (frame_height_ff),
      .cell_scale   (cell_scale_ff),
      .rect         (rect)
   );

   cspr_output u_output (
      .clock          (clock),
      .reset          (reset),
      .rect           (rect),
      .advance        (advance),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_rect_x     (rsp_rect_x),
      .rsp_rect_y     (rsp_rect_y),
      .rsp_rect_w     (rsp_rect_w),
      .rsp_rect_h     (rsp_rect_h),
      .rsp_fill_color (rsp_fill_color),
      .rsp_last       (rsp_last)
   );

   assign draw_accept  = req_valid && !req_stall && req_shown
                         && frame_width_ff != '0 && frame_height_ff != '0;
   assign rect_empty   = (rsp_rect_w == '0) || (rsp_rect_h == '0);
   assign idx_past_end = (issue.idx >= cspr_pkg::run_idx_type'(cspr_pkg::RUN_COUNT));

   `CSPR_ASSERT_NEXT(a_draw_holds_input, draw_accept, req_stall, "drawn request not held")
   `CSPR_ASSERT_NOW(a_rect_not_empty, rsp_valid, !rect_empty, "empty rectangle on rsp")
   `CSPR_ASSERT_NOW(a_issue_in_range, issue.valid, !idx_past_end, "run index past table end")

endmodule

[rtl/cspr_sequencer.sv]
module cspr_sequencer (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  cspr_pkg::coord_type   req_hot_x,
   input  cspr_pkg::coord_type   req_hot_y,
   input  logic                  req_shown,
   input  cspr_pkg::frame_type   frame_width,
   input  cspr_pkg::frame_type   frame_height,
   input  logic                  advance,
   output cspr_pkg::issue_type   issue
);

   cspr_pkg::seq_state_type state_ff, state_in;
   cspr_pkg::run_idx_type   idx_ff, idx_in;
   cspr_pkg::coord_type     x_ff, x_in;
   cspr_pkg::base_type      base_ff, base_in;
   cspr_pkg::frame_type     h_lim;
   logic                    accept;
   logic                    draw;
   logic                    at_end;

   assign h_lim  = cspr_pkg::frame_clamp(frame_height);
   assign draw   = req_shown && (frame_width != '0) && (frame_height != '0);
   assign accept = req_valid && !req_stall;
   assign at_end = (idx_ff == cspr_pkg::run_idx_type'(cspr_pkg::RUN_COUNT - 1));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cspr_pkg::SEQ_IDLE: begin
            if (accept && draw) state_in = cspr_pkg::SEQ_RUN;
         end
         cspr_pkg::SEQ_RUN: begin
            if (advance && at_end) state_in = cspr_pkg::SEQ_IDLE;
         end
         default: state_in = cspr_pkg::SEQ_IDLE;
      endcase
   end

   always_comb begin
      req_stall      = (state_ff == cspr_pkg::SEQ_RUN);
      issue.valid    = (state_ff == cspr_pkg::SEQ_RUN);
      issue.last_run = at_end;
      issue.idx      = idx_ff;
      issue.x        = x_ff;
      issue.base     = base_ff;
   end

   always_comb begin
      idx_in  = idx_ff;
      x_in    = x_ff;
      base_in = base_ff;
      if (accept && draw) begin
         idx_in  = '0;
         x_in    = req_hot_x;
         base_in = $signed({1'b0, h_lim}) - $signed({req_hot_y[12], req_hot_y})
                   - 14'sd1;
      end else if (state_ff == cspr_pkg::SEQ_RUN && advance && !at_end) begin
         idx_in = idx_ff + cspr_pkg::run_idx_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cspr_pkg::SEQ_IDLE;
         idx_ff   <= '0;
         x_ff     <= '0;
         base_ff  <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         x_ff     <= x_in;
         base_ff  <= base_in;
      end
   end

endmodule

[rtl/cspr_geometry.sv]
module cspr_geometry (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  cspr_pkg::issue_type  issue,
   input  cspr_pkg::frame_type  frame_width,
   input  cspr_pkg::frame_type  frame_height,
   input  cspr_pkg::scale_type  cell_scale,
   output cspr_pkg::rect_type   rect
);

   // stage 1: table read and products
   cspr_pkg::run_type   run;
   logic                v1_ff, last1_ff, color1_ff;
   cspr_pkg::coord_type x1_ff;
   cspr_pkg::base_type  base1_ff;
   cspr_pkg::prod_type  bs1_ff, ls1_ff, rs1_ff;
   cspr_pkg::prod_type  bs_in, ls_in, rs_in;

   // stage 2: placement
   logic                v2_ff, last2_ff, color2_ff;
   cspr_pkg::geo_type   xs2_ff, xe2_ff, ys2_ff, ye2_ff;
   cspr_pkg::geo_type   xs_in, xe_in, ys_in, ye_in;

   // stage 3: clipping
   logic                v3_ff, last3_ff, color3_ff, keep3_ff;
   cspr_pkg::pos_type   rx3_ff, ry3_ff;
   cspr_pkg::size_type  rw3_ff, rh3_ff;
   cspr_pkg::geo_type   wl, hl, x0, y0, xc, yc;
   logic                keep_in;

   assign run   = cspr_pkg::RUN_TABLE[issue.idx];
   assign bs_in = cspr_pkg::prod_type'(run.col) * cspr_pkg::prod_type'(cell_scale);
   assign ls_in = cspr_pkg::prod_type'(run.len) * cspr_pkg::prod_type'(cell_scale);
   assign rs_in = cspr_pkg::prod_type'(run.row) * cspr_pkg::prod_type'(cell_scale);

   assign xs_in = cspr_pkg::geo_type'(x1_ff) + cspr_pkg::geo_type'(bs1_ff);
   assign xe_in = xs_in + cspr_pkg::geo_type'(ls1_ff);
   assign ys_in = cspr_pkg::geo_type'(base1_ff) - cspr_pkg::geo_type'(rs1_ff);
   assign ye_in = ys_in + cspr_pkg::geo_type'(cell_scale);

   assign wl      = cspr_pkg::geo_type'(cspr_pkg::frame_clamp(frame_width));
   assign hl      = cspr_pkg::geo_type'(cspr_pkg::frame_clamp(frame_height));
   assign x0      = xs2_ff[14] ? '0 : xs2_ff;
   assign y0      = ys2_ff[14] ? '0 : ys2_ff;
   assign xc      = (xe2_ff > wl) ? wl : xe2_ff;
   assign yc      = (ye2_ff > hl) ? hl : ye2_ff;
   assign keep_in = (xc > x0) && (yc > y0);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= issue.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         last1_ff  <= issue.last_run;
         color1_ff <= run.color;
         x1_ff     <= issue.x;
         base1_ff  <= issue.base;
         bs1_ff    <= bs_in;
         ls1_ff    <= ls_in;
         rs1_ff    <= rs_in;

         last2_ff  <= last1_ff;
         color2_ff <= color1_ff;
         xs2_ff    <= xs_in;
         xe2_ff    <= xe_in;
         ys2_ff    <= ys_in;
         ye2_ff    <= ye_in;

         last3_ff  <= last2_ff;
         color3_ff <= color2_ff;
         keep3_ff  <= keep_in;
         rx3_ff    <= cspr_pkg::pos_type'(x0);
         ry3_ff    <= cspr_pkg::pos_type'(y0);
         rw3_ff    <= cspr_pkg::size_type'(xc - x0);
         rh3_ff    <= cspr_pkg::size_type'(yc - y0);
      end
   end

   always_comb begin
      rect.valid    = v3_ff;
      rect.last_run = last3_ff;
      rect.keep     = keep3_ff;
      rect.color    = color3_ff;
      rect.x        = rx3_ff;
      rect.y        = ry3_ff;
      rect.w        = rw3_ff;
      rect.h        = rh3_ff;
   end

endmodule

[rtl/cspr_output.sv]
module cspr_output (
   input  logic                clock,
   input  logic                reset,
   input  cspr_pkg::rect_type  rect,
   output logic                advance,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output cspr_pkg::pos_type   rsp_rect_x,
   output cspr_pkg::pos_type   rsp_rect_y,
   output cspr_pkg::size_type  rsp_rect_w,
   output cspr_pkg::size_type  rsp_rect_h,
   output logic                rsp_fill_color,
   output logic                rsp_last
);

   // hold one survivor back until the next one or the run end shows up
   logic               hold_v_ff, hold_v_in;
   logic               hold_fin_ff, hold_fin_in;
   cspr_pkg::rect_type hold_ff;
   logic               out_v_ff, out_v_in;
   logic               out_last_ff;
   cspr_pkg::rect_type out_ff;
   logic               take;
   logic               move;

   assign advance = !out_v_ff || !rsp_stall;
   assign take    = rect.valid && rect.keep;
   assign move    = advance && hold_v_ff && (hold_fin_ff || take);

   always_comb begin
      out_v_in    = out_v_ff;
      hold_v_in   = hold_v_ff;
      hold_fin_in = hold_fin_ff;
      if (advance) begin
         out_v_in = move;
         if (take) begin
            hold_v_in   = 1'b1;
            hold_fin_in = rect.last_run;
         end else if (move) begin
            hold_v_in   = 1'b0;
            hold_fin_in = 1'b0;
         end else if (rect.valid && rect.last_run && hold_v_ff) begin
            hold_fin_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff    <= 1'b0;
         hold_v_ff   <= 1'b0;
         hold_fin_ff <= 1'b0;
      end else begin
         out_v_ff    <= out_v_in;
         hold_v_ff   <= hold_v_in;
         hold_fin_ff <= hold_fin_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && take) hold_ff <= rect;
      if (move) begin
         out_ff      <= hold_ff;
         out_last_ff <= hold_fin_ff;
      end
   end

   assign rsp_valid      = out_v_ff;
   assign rsp_rect_x     = out_ff.x;
   assign rsp_rect_y     = out_ff.y;
   assign rsp_rect_w     = out_ff.w;
   assign rsp_rect_h     = out_ff.h;
   assign rsp_fill_color = out_ff.color;
   assign rsp_last       = out_last_ff;

endmodule
